// File: sv/radix_page_table_walker_macros.svh
// Assertion helpers for the walker's top-level RTL file.
`ifndef RADIX_PAGE_TABLE_WALKER_MACROS_SVH
`define RADIX_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define RPTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define RPTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rptw_pkg.sv
package rptw_pkg;

  localparam int FRAMES         = 64;
  localparam int POINTER_LEVELS = 5;
  localparam int INDEX_BITS     = 9;

  localparam int ENTRY_W   = 64;
  localparam int PAGE_SH   = 12;
  localparam int PFN_W     = ENTRY_W - PAGE_SH;
  localparam int VPN_W     = 54;
  localparam int PPN_W     = 52;
  localparam int TOP_SH    = 45;
  localparam int ROOT_W    = 6;
  localparam int BASE_W    = 7;
  localparam int FRAME_W   = (FRAMES > 2) ? $clog2(FRAMES) : 1;
  localparam int ADDR_W    = FRAME_W + INDEX_BITS;
  localparam int DEPTH     = FRAMES * (1 << INDEX_BITS);
  localparam int NF_W      = ($clog2(FRAMES + 1) > BASE_W) ? $clog2(FRAMES + 1) : BASE_W;
  localparam int LVL_W     = 3;
  localparam int UPC_W     = 4;

  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_OOF = 2'd1,
    STAT_PTR = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_ROOT_FRAME = 1'b0,
    CFG_ALLOC_BASE = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_READ,
    ACT_AWRITE,
    ACT_FOLLOW,
    ACT_LWRITE,
    ACT_FIN_OK,
    ACT_FIN_OOF,
    ACT_FIN_PTR
  } act_t;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_START,
    C_CLR_LAST,
    C_FRAME_BAD,
    C_AT_LEAF,
    C_Q_INVALID,
    C_NEED_ALLOC,
    C_OUT_OF_FRAMES,
    C_IS_QUERY
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } uword_t;

  typedef struct packed {
    logic start;
    logic clr_last;
    logic frame_bad;
    logic at_leaf;
    logic q_invalid;
    logic need_alloc;
    logic out_of_frames;
    logic is_query;
  } flags_t;

  localparam upc_t U_CLR     = 4'd0;
  localparam upc_t U_IDLE    = 4'd1;
  localparam upc_t U_CHKF    = 4'd2;
  localparam upc_t U_RD      = 4'd3;
  localparam upc_t U_PTR     = 4'd4;
  localparam upc_t U_QINV    = 4'd5;
  localparam upc_t U_NEEDA   = 4'd6;
  localparam upc_t U_ALLOC   = 4'd7;
  localparam upc_t U_AWRITE  = 4'd8;
  localparam upc_t U_FOLLOW  = 4'd9;
  localparam upc_t U_LEAF    = 4'd10;
  localparam upc_t U_LWRITE  = 4'd11;
  localparam upc_t U_FIN_OK  = 4'd12;
  localparam upc_t U_FIN_OOF = 4'd13;
  localparam upc_t U_FIN_PTR = 4'd14;

  // The walk program. A step jumps to tgt_t when its condition holds, else to tgt_f.
  function automatic uword_t ucode(upc_t a);
    uword_t w;
    unique case (a)
      U_CLR:     w = '{ACT_CLR,     C_CLR_LAST,      U_IDLE,    U_CLR};
      U_IDLE:    w = '{ACT_NONE,    C_START,         U_CHKF,    U_IDLE};
      U_CHKF:    w = '{ACT_NONE,    C_FRAME_BAD,     U_FIN_PTR, U_RD};
      U_RD:      w = '{ACT_READ,    C_ALWAYS,        U_PTR,     U_PTR};
      U_PTR:     w = '{ACT_NONE,    C_AT_LEAF,       U_LEAF,    U_QINV};
      U_QINV:    w = '{ACT_NONE,    C_Q_INVALID,     U_FIN_OK,  U_NEEDA};
      U_NEEDA:   w = '{ACT_NONE,    C_NEED_ALLOC,    U_ALLOC,   U_FOLLOW};
      U_ALLOC:   w = '{ACT_NONE,    C_OUT_OF_FRAMES, U_FIN_OOF, U_AWRITE};
      U_AWRITE:  w = '{ACT_AWRITE,  C_ALWAYS,        U_CHKF,    U_CHKF};
      U_FOLLOW:  w = '{ACT_FOLLOW,  C_ALWAYS,        U_CHKF,    U_CHKF};
      U_LEAF:    w = '{ACT_NONE,    C_IS_QUERY,      U_FIN_OK,  U_LWRITE};
      U_LWRITE:  w = '{ACT_LWRITE,  C_ALWAYS,        U_FIN_OK,  U_FIN_OK};
      U_FIN_OK:  w = '{ACT_FIN_OK,  C_ALWAYS,        U_IDLE,    U_IDLE};
      U_FIN_OOF: w = '{ACT_FIN_OOF, C_ALWAYS,        U_IDLE,    U_IDLE};
      U_FIN_PTR: w = '{ACT_FIN_PTR, C_ALWAYS,        U_IDLE,    U_IDLE};
      default:   w = '{ACT_NONE,    C_ALWAYS,        U_IDLE,    U_IDLE};
    endcase
    return w;
  endfunction

  // Nine-bit index of walk step lvl; past the last group of bits the index is zero.
  function automatic logic [INDEX_BITS-1:0] step_idx(logic [VPN_W-1:0] vpn,
                                                     logic [LVL_W-1:0] lvl);
    logic [INDEX_BITS-1:0] idx;
    unique case (lvl)
      3'd0:    idx = vpn[TOP_SH                  +: INDEX_BITS];
      3'd1:    idx = vpn[TOP_SH - INDEX_BITS     +: INDEX_BITS];
      3'd2:    idx = vpn[TOP_SH - 2 * INDEX_BITS +: INDEX_BITS];
      3'd3:    idx = vpn[TOP_SH - 3 * INDEX_BITS +: INDEX_BITS];
      3'd4:    idx = vpn[TOP_SH - 4 * INDEX_BITS +: INDEX_BITS];
      3'd5:    idx = vpn[TOP_SH - 5 * INDEX_BITS +: INDEX_BITS];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

// File: sv/radix_page_table_walker.sv
// Radix page table walker. After reset the block clears its frame store, one word a
// cycle, with busy high; configuration writes are taken throughout. A word is accepted
// when start is high and busy is low. A walk is stepped by a small microprogram, one
// control word a cycle, over one store with a registered read port: each pointer level
// checks its frame, reads the entry, tests it and then follows it or allocates and
// writes a new frame; the leaf checks its frame, reads and tests its entry and, on an
// update, writes it. A full walk has six steps and an early stop ends it sooner. The
// result is shown for exactly one cycle under out_valid, in the cycle after the walk's
// final step; the receiver cannot hold it off, so it must take every result word the
// cycle it appears.
`include "radix_page_table_walker_macros.svh"

module radix_page_table_walker
  import rptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [VPN_W-1:0]  in_vpn,
  input  logic              in_unmap,
  input  logic [PPN_W-1:0]  in_new_ppn,
  output logic              out_valid,
  output logic              out_mapped,
  output logic [PPN_W-1:0]  out_ppn,
  output logic [1:0]        out_status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [BASE_W-1:0] cfg_data
);

  uword_t uw;
  flags_t flags;
  logic   accept;

  logic               req_r;
  logic [VPN_W-1:0]   vpn_r;
  logic               unmap_r;
  logic [PPN_W-1:0]   new_ppn_r;
  logic [FRAME_W-1:0] frame_r;
  logic               bad_r;
  logic [LVL_W-1:0]   lvl_r;
  logic [NF_W-1:0]    nf_r;
  logic [ROOT_W-1:0]  root_r;
  logic [ADDR_W-1:0]  clr_r;

  logic              out_valid_r;
  logic              out_mapped_r;
  logic [PPN_W-1:0]  out_ppn_r;
  status_t           out_status_r;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, walk_addr;
  logic [ENTRY_W-1:0]  ram_wdata, pte;
  logic [PFN_W-1:0]    pte_pfn;
  logic                leaf_hit;

  rptw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .uw    (uw),
    .busy  (busy)
  );

  rptw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (walk_addr),
    .rdata (pte)
  );

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign walk_addr = {frame_r, step_idx(vpn_r, lvl_r)};
  assign pte_pfn   = pte[ENTRY_W-1:PAGE_SH];
  assign leaf_hit  = !req_r && (lvl_r == LVL_W'(POINTER_LEVELS)) && pte[0];

  always_comb begin
    flags.start         = start;
    flags.clr_last      = (clr_r == ADDR_W'(DEPTH - 1));
    flags.frame_bad     = bad_r;
    flags.at_leaf       = (lvl_r == LVL_W'(POINTER_LEVELS));
    flags.q_invalid     = !req_r && !pte[0];
    flags.need_alloc    = req_r && (pte == '0);
    flags.out_of_frames = (nf_r >= NF_W'(FRAMES));
    flags.is_query      = !req_r;
  end

  // Store write port: clearing pass, pointer allocation and leaf update share it.
  always_comb begin
    ram_re    = (uw.act == ACT_READ);
    ram_we    = 1'b0;
    ram_waddr = walk_addr;
    ram_wdata = '0;
    unique case (uw.act)
      ACT_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      ACT_AWRITE: begin
        ram_we    = 1'b1;
        ram_wdata = (ENTRY_W'(nf_r) << PAGE_SH) | ENTRY_W'(1);
      end
      ACT_LWRITE: begin
        ram_we    = 1'b1;
        ram_wdata = unmap_r ? {pte[ENTRY_W-1:1], 1'b0}
                            : {new_ppn_r, {(PAGE_SH-1){1'b0}}, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      root_r      <= '0;
      nf_r        <= NF_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (uw.act == ACT_CLR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      // A write of the allocator base takes precedence over an allocation step.
      if (cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_ALLOC_BASE)) begin
        nf_r <= NF_W'(cfg_data);
      end else if (uw.act == ACT_AWRITE) begin
        nf_r <= nf_r + NF_W'(1);
      end
      if (cfg_valid && cfg_ready && (cfg_idx_t'(cfg_index) == CFG_ROOT_FRAME)) begin
        root_r <= cfg_data[ROOT_W-1:0];
      end
      out_valid_r <= (uw.act == ACT_FIN_OK) || (uw.act == ACT_FIN_OOF) ||
                     (uw.act == ACT_FIN_PTR);
    end
  end

  // Walk datapath and result word; none of it needs a reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r     <= in_req_type;
      vpn_r     <= in_vpn;
      unmap_r   <= in_unmap;
      new_ppn_r <= in_new_ppn;
      frame_r   <= FRAME_W'(root_r);
      bad_r     <= (PFN_W'(root_r) >= PFN_W'(FRAMES));
      lvl_r     <= '0;
    end
    unique case (uw.act)
      ACT_AWRITE: begin
        frame_r <= nf_r[FRAME_W-1:0];
        bad_r   <= 1'b0;
        lvl_r   <= lvl_r + LVL_W'(1);
      end
      ACT_FOLLOW: begin
        frame_r <= pte_pfn[FRAME_W-1:0];
        bad_r   <= (pte_pfn >= PFN_W'(FRAMES));
        lvl_r   <= lvl_r + LVL_W'(1);
      end
      ACT_FIN_OK: begin
        out_mapped_r <= leaf_hit;
        out_ppn_r    <= leaf_hit ? pte_pfn : '0;
        out_status_r <= STAT_OK;
      end
      ACT_FIN_OOF: begin
        out_mapped_r <= 1'b0;
        out_ppn_r    <= '0;
        out_status_r <= STAT_OOF;
      end
      ACT_FIN_PTR: begin
        out_mapped_r <= 1'b0;
        out_ppn_r    <= '0;
        out_status_r <= STAT_PTR;
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_mapped = out_mapped_r;
  assign out_ppn    = out_ppn_r;
  assign out_status = out_status_r;

  `RPTW_ASSERT_NXT(a_single_word, out_valid, !out_valid, "result word held for two cycles")
  `RPTW_ASSERT_NXT(a_busy_after_accept, accept, busy, "walk did not start after accept")
  `RPTW_ASSERT_IMP(a_mapped_ok, out_valid && out_mapped, out_status == STAT_OK,
                   "mapped result carries an error status")
  `RPTW_ASSERT_IMP(a_write_in_store, ram_we,
                   ram_waddr[ADDR_W-1:INDEX_BITS] < FRAME_W'(FRAMES - 1) ||
                   ram_waddr[ADDR_W-1:INDEX_BITS] == FRAME_W'(FRAMES - 1),
                   "store write beyond the last frame")

endmodule

// File: sv/rptw_ram.sv
module rptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/rptw_seq.sv
module rptw_seq
  import rptw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output uword_t uw,
  output logic   busy
);

  upc_t upc_r, upc_nxt;
  logic hit;

  assign uw   = ucode(upc_r);
  assign busy = (upc_r != U_IDLE);

  always_comb begin
    unique case (uw.cond)
      C_ALWAYS:        hit = 1'b1;
      C_START:         hit = flags.start;
      C_CLR_LAST:      hit = flags.clr_last;
      C_FRAME_BAD:     hit = flags.frame_bad;
      C_AT_LEAF:       hit = flags.at_leaf;
      C_Q_INVALID:     hit = flags.q_invalid;
      C_NEED_ALLOC:    hit = flags.need_alloc;
      C_OUT_OF_FRAMES: hit = flags.out_of_frames;
      C_IS_QUERY:      hit = flags.is_query;
      default:         hit = 1'b1;
    endcase
    upc_nxt = hit ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule
